### rtl/core/assert_macros.svh
// Assertion macros included by the core writer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console character writer.
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int CELL_W         = $clog2(CELL_COUNT);
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int CELL_INDEX_W   = 11;
    localparam int CHAR_W         = 8;
    localparam int ATTR_W         = 8;
    localparam int TAB_W          = 5;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    localparam logic [TAB_W-1:0]  MAX_TAB        = 5'd16;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd2;
    localparam logic [TAB_W-1:0]  TAB_RESET      = 5'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAB_LENGTH     = 1'b1;

    // Cursor position: linear cell address plus the column it sits in.
    typedef struct packed {
        logic [CELL_W-1:0] addr;
        logic [COL_W-1:0]  col;
    } pos_t;

    typedef enum logic [1:0] {
        STEP_INC,
        STEP_DEC,
        STEP_NEWLINE
    } step_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } fsm_t;

endpackage

### rtl/core/text_console_char_writer_core.sv
// Text console character writer: cursor sequencer, config registers and output register.
// Each accepted character is held while a small sequencer drives one shared cursor step
// unit, one step per cycle while the output register is free (out_valid low or out_ready
// high): a printable byte, a backspace or a newline takes a single step, and a tab writes
// tab_length blank cells, one per step (tab_length saturated at 16; no cell when it is zero).
// in_ready is high only between characters. A newline, and a backspace at cell zero,
// produce no cell write. Registers (text_attribute, tab_length) are written through cfg_we,
// cfg_index and cfg_data; tab_length is sampled when a character is accepted and
// text_attribute at each cell write.
module text_console_char_writer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]           char_code,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tcw_pkg::CELL_INDEX_W-1:0]     cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]           cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]           cell_attr,
    output logic                                 last_cell
);
    import tcw_pkg::*;

    `include "assert_macros.svh"

    fsm_t              state_reg, state_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [TAB_W-1:0]  count_reg, count_next;
    pos_t              cursor_reg, cursor_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [TAB_W-1:0]  tab_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [CELL_INDEX_W-1:0] index_reg, index_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic [ATTR_W-1:0]       out_attr_reg;
    logic                    last_reg, last_next;

    logic              load;
    logic              slot_free;
    logic [TAB_W-1:0]  tab_len;
    step_op_t          step_op;
    pos_t              step_pos;

    // Shared cursor step unit
    tcw_step u_step (
        .pos      (cursor_reg),
        .op       (step_op),
        .pos_next (step_pos)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
            tab_reg  <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_ATTRIBUTE: attr_reg <= cfg_data;
                REG_TAB_LENGTH:     tab_reg  <= cfg_data[TAB_W-1:0];
                default:            attr_reg <= attr_reg;
            endcase
        end
    end

    // Saturate the tab length
    assign tab_len   = (tab_reg > MAX_TAB) ? MAX_TAB : tab_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // Sequencer: next state, cursor and output load
    always_comb
    begin
        state_next    = state_reg;
        char_next     = char_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        step_op       = STEP_INC;
        load          = 1'b0;
        index_next    = CELL_INDEX_W'(cursor_reg.addr);
        out_char_next = char_reg;
        last_next     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the request
                if (in_valid)
                begin
                    char_next  = char_code;
                    count_next = tab_len;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    priority if (char_reg == CODE_NEWLINE)
                    begin
                        step_op     = STEP_NEWLINE;
                        cursor_next = step_pos;
                        state_next  = ST_IDLE;
                    end
                    else if (char_reg == CODE_TAB)
                    begin
                        // One blank cell per step until the count runs out
                        if (count_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            load          = 1'b1;
                            out_char_next = CODE_SPACE;
                            last_next     = (count_reg == TAB_W'(1));
                            cursor_next   = step_pos;
                            count_next    = count_reg - 1'b1;
                            if (count_reg == TAB_W'(1))
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    else if (char_reg == CODE_BACKSPACE)
                    begin
                        // Step back and blank, nothing at cell zero
                        step_op = STEP_DEC;
                        if (cursor_reg.addr != '0)
                        begin
                            load          = 1'b1;
                            cursor_next   = step_pos;
                            index_next    = CELL_INDEX_W'(step_pos.addr);
                            out_char_next = CODE_SPACE;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Printable: write at the cursor and advance
                        load        = 1'b1;
                        cursor_next = step_pos;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (load)
        begin
            index_reg    <= index_next;
            out_char_reg <= out_char_next;
            out_attr_reg <= attr_reg;
            last_reg     <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_index = index_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign last_cell  = last_reg;

    // Cursor stays on the screen and its column stays in range
    `ASSERT_IMPLIES(a_cursor_range, clk, rst_n, 1'b1,
                    cursor_reg.addr <= CELL_W'(CELL_COUNT - 1))
    `ASSERT_IMPLIES(a_col_range, clk, rst_n, 1'b1,
                    cursor_reg.col <= COL_W'(SCREEN_COLUMNS - 1))
    // A final cell write ends the character
    `ASSERT_NEXT(a_last_ends, clk, rst_n, load && last_next, state_reg == ST_IDLE)

endmodule

### rtl/core/tcw_step.sv
// Shared cursor step unit: advance, step back or go to the next row start.
module tcw_step (
    input  tcw_pkg::pos_t     pos,
    input  tcw_pkg::step_op_t op,
    output tcw_pkg::pos_t     pos_next
);
    import tcw_pkg::*;

    localparam logic [CELL_W-1:0] LAST_CELL     = CELL_W'(CELL_COUNT - 1);
    localparam logic [CELL_W-1:0] LAST_ROW_BASE = CELL_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [CELL_W-1:0] ROW_STRIDE    = CELL_W'(SCREEN_COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(SCREEN_COLUMNS - 1);

    logic [CELL_W-1:0] row_base;

    // Start of the current row
    assign row_base = pos.addr - CELL_W'(pos.col);

    always_comb
    begin
        pos_next = pos;
        unique case (op)
            STEP_INC:
            begin
                // Advance one cell, wrap past the last cell to the top left
                if (pos.addr == LAST_CELL)
                begin
                    pos_next.addr = '0;
                    pos_next.col  = '0;
                end
                else
                begin
                    pos_next.addr = pos.addr + 1'b1;
                    pos_next.col  = (pos.col == LAST_COL) ? '0 : pos.col + 1'b1;
                end
            end
            STEP_DEC:
            begin
                // Step back one cell; caller keeps this off cell zero
                pos_next.addr = pos.addr - 1'b1;
                pos_next.col  = (pos.col == '0) ? LAST_COL : pos.col - 1'b1;
            end
            STEP_NEWLINE:
            begin
                // Jump to the next row start, last row wraps to the top
                pos_next.addr = (row_base == LAST_ROW_BASE) ? '0 : row_base + ROW_STRIDE;
                pos_next.col  = '0;
            end
            default:
            begin
                pos_next = pos;
            end
        endcase
    end

endmodule
